// ===== design/csim_pkg.sv =====
// Shared constants for the cosine similarity unit.
`default_nettype none

package csim_pkg;

    localparam int MAX_LEN_DEF = 128;
    localparam int DATA_W      = 16;
    localparam int FRAC_W      = 30;
    localparam int K_W         = 4;
    localparam int TDATA_IN_W  = 2 * DATA_W;
    localparam int TDATA_OUT_W = DATA_W;

    localparam logic [DATA_W-1:0] SIM_MAX = 16'h7FFF;

endpackage

`default_nettype wire

// ===== design/cosine_similarity_unit.sv =====
// Cosine similarity of two streamed Q1.15 vectors, sequenced over one shared datapath.
//
// Slave stream: one element pair per word, tlast on the final pair of the vectors.
// Master stream: one word per vector pair, similarity in Q1.15 and a zero-norm flag.
// Each accepted element pair goes through the shared 16x16 multiplier
// (three products, then the last accumulate); ready is low meanwhile, so the block
// takes no new pair until it is through with the last. Pairs beyond MAX_LEN are dropped.
// On the tlast word the block then runs a norm check, two serial shift-add
// multiplies (MAG_W = 30 + clog2(MAX_LEN+1), 38 at the default), and a 16-bit
// root/quotient bit search through states S_SQ1 and S_SQ2 for each bit.
// When a norm is zero the multiplies and the bit search are skipped.
// The result sits in an output register; the block takes new element pairs while it
// waits. Only a second result finding the register still full stalls the block.
// Reset (synchronous, active low) clears the accumulators, the element count, the
// sequencer and the output valid.
`default_nettype none

module cosine_similarity_unit
    import csim_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [TDATA_IN_W-1:0]  i_s_axis_tdata,   // elem_a [15:0], elem_b [31:16]
    input  wire logic                   i_s_axis_tlast,   // last_elem
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic [TDATA_OUT_W-1:0]      o_m_axis_tdata,   // similarity [15:0]
    output logic                        o_m_axis_tuser    // zero_norm
);

    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int MAG_W  = FRAC_W + CNT_W;
    localparam int DOT_W  = MAG_W + 1;
    localparam int PROD_W = 2 * MAG_W;
    localparam int W      = PROD_W + 32;
    localparam int MC_W   = $clog2(MAG_W);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_MP   = 4'd3;
    localparam logic [3:0] S_MR   = 4'd4;
    localparam logic [3:0] S_SQ1  = 4'd5;
    localparam logic [3:0] S_SQ2  = 4'd6;
    localparam logic [3:0] S_DONE = 4'd7;

    logic [3:0]                r_state;
    logic [1:0]                r_ph;
    logic signed [DATA_W-1:0]  r_a;
    logic signed [DATA_W-1:0]  r_b;
    logic                      r_last;
    logic signed [31:0]        r_prod;
    logic signed [DOT_W-1:0]   r_dot;
    logic [MAG_W-1:0]          r_na;
    logic [MAG_W-1:0]          r_nb;
    logic [CNT_W-1:0]          r_cnt;
    logic [MAG_W-1:0]          r_mhi;
    logic [MAG_W-1:0]          r_mlo;
    logic [MAG_W-1:0]          r_mcand;
    logic [MC_W-1:0]           r_mcnt;
    logic [PROD_W-1:0]         r_p;
    logic [W-1:0]              r_r;
    logic [W-1:0]              r_s;
    logic [W-1:0]              r_v;
    logic [W-1:0]              r_p2k;
    logic [W-1:0]              r_t1;
    logic [K_W-1:0]            r_k;
    logic [DATA_W-1:0]         r_q;
    logic                      r_neg;
    logic                      r_zn;
    logic                      r_out_valid;
    logic [DATA_W-1:0]         r_out_sim;
    logic                      r_out_zn;

    logic signed [DATA_W-1:0]  op_x;
    logic signed [DATA_W-1:0]  op_y;
    logic signed [31:0]        mul;
    logic [MAG_W:0]            msum;
    logic [PROD_W-1:0]         mprod;
    logic [MAG_W-1:0]          dot_mag;
    logic [W-1:0]              cand;
    logic                      cand_ok;
    logic [W-1:0]              v_upd;
    logic [DATA_W-1:0]         sim;
    logic                      s_acc;
    logic                      out_free;

    assign s_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;

    assign op_x = (r_ph == 2'd2) ? r_b : r_a;
    assign op_y = (r_ph == 2'd1) ? r_a : r_b;
    assign mul  = op_x * op_y;

    assign msum  = {1'b0, r_mhi} + (r_mlo[0] ? {1'b0, r_mcand} : {(MAG_W + 1){1'b0}});
    assign mprod = {msum[MAG_W:1], msum[0], r_mlo[MAG_W-1:1]};

    assign dot_mag = r_dot[DOT_W-1] ? MAG_W'(-r_dot) : MAG_W'(r_dot);

    assign cand    = r_t1 + r_p2k;
    assign cand_ok = cand <= r_r;
    assign v_upd   = cand_ok ? r_v + (r_p2k << 1) : r_v;

    always_comb begin
        if (r_zn) begin
            sim = '0;
        end else if (r_neg) begin
            sim = -r_q;
        end else if (r_q[DATA_W-1]) begin
            sim = SIM_MAX;
        end else begin
            sim = r_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ph        <= '0;
            r_dot       <= '0;
            r_na        <= '0;
            r_nb        <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_axis_tready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_a    <= i_s_axis_tdata[DATA_W-1:0];
                        r_b    <= i_s_axis_tdata[TDATA_IN_W-1:DATA_W];
                        r_last <= i_s_axis_tlast;
                        r_ph   <= '0;
                        if (r_cnt != CNT_W'(MAX_LEN)) begin
                            r_state <= S_MUL;
                        end else if (i_s_axis_tlast) begin
                            r_state <= S_CHK;
                        end
                    end
                end
                S_MUL: begin
                    r_prod <= mul;
                    r_ph   <= r_ph + 2'd1;
                    case (r_ph)
                        2'd1: r_dot <= r_dot + DOT_W'(r_prod);
                        2'd2: r_na  <= r_na + MAG_W'(r_prod[FRAC_W:0]);
                        2'd3: begin
                            r_nb    <= r_nb + MAG_W'(r_prod[FRAC_W:0]);
                            r_cnt   <= r_cnt + CNT_W'(1);
                            r_state <= r_last ? S_CHK : S_IDLE;
                        end
                        default: ;
                    endcase
                end
                S_CHK: begin
                    r_neg  <= r_dot[DOT_W-1];
                    r_q    <= '0;
                    r_mcnt <= '0;
                    if (r_na == '0 || r_nb == '0) begin
                        r_zn    <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_zn    <= 1'b0;
                        r_mhi   <= '0;
                        r_mlo   <= r_na;
                        r_mcand <= r_nb;
                        r_state <= S_MP;
                    end
                end
                S_MP: begin
                    if (r_mcnt == MC_W'(MAG_W - 1)) begin
                        r_p     <= mprod;
                        r_mhi   <= '0;
                        r_mlo   <= dot_mag;
                        r_mcand <= dot_mag;
                        r_mcnt  <= '0;
                        r_state <= S_MR;
                    end else begin
                        r_mhi  <= msum[MAG_W:1];
                        r_mlo  <= {msum[0], r_mlo[MAG_W-1:1]};
                        r_mcnt <= r_mcnt + MC_W'(1);
                    end
                end
                S_MR: begin
                    r_mhi  <= msum[MAG_W:1];
                    r_mlo  <= {msum[0], r_mlo[MAG_W-1:1]};
                    r_mcnt <= r_mcnt + MC_W'(1);
                    if (r_mcnt == MC_W'(MAG_W - 1)) begin
                        r_r     <= W'(mprod) << FRAC_W;
                        r_s     <= '0;
                        r_v     <= '0;
                        r_p2k   <= W'(r_p) << FRAC_W;
                        r_k     <= '1;
                        r_state <= S_SQ1;
                    end
                end
                S_SQ1: begin
                    r_t1    <= r_s + r_v;
                    r_state <= S_SQ2;
                end
                S_SQ2: begin
                    if (cand_ok) begin
                        r_s <= cand;
                        r_q <= r_q | (DATA_W'(1) << r_k);
                    end
                    r_v   <= v_upd >> 1;
                    r_p2k <= r_p2k >> 2;
                    r_k   <= r_k - K_W'(1);
                    r_state <= (r_k == '0) ? S_DONE : S_SQ1;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_sim   <= sim;
                        r_out_zn    <= r_zn;
                        r_dot       <= '0;
                        r_na        <= '0;
                        r_nb        <= '0;
                        r_cnt       <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_sim;
    assign o_m_axis_tuser  = r_out_zn;

endmodule

`default_nettype wire

// ===== design/csim_checker.sv =====
// Port-level checks for the cosine similarity unit, bound to its top level.
`default_nettype none

module csim_checker
    import csim_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_s_axis_tvalid,
    input wire logic                   o_s_axis_tready,
    input wire logic                   i_s_axis_tlast,
    input wire logic                   o_m_axis_tvalid,
    input wire logic                   i_m_axis_tready,
    input wire logic [TDATA_OUT_W-1:0] o_m_axis_tdata,
    input wire logic                   o_m_axis_tuser
);

    // result word held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid
            && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result word changed while stalled");

    a_zero_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("zero norm with non-zero similarity");

    // the final pair always starts the result sequence
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast |=> !o_s_axis_tready)
        else $error("ready after final pair");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind cosine_similarity_unit csim_checker u_csim_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire

// ===== test/cosine_similarity_checker.sv =====
// Stream checker for the cosine similarity unit: predicts each result word and compares.
`timescale 1ns / 1ps

module cosine_similarity_checker
    import csim_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    input  wire logic                   i_s_axis_tready,
    input  wire logic [TDATA_IN_W-1:0]  i_s_axis_tdata,   // elem_a [15:0], elem_b [31:16]
    input  wire logic                   i_s_axis_tlast,   // last_elem
    input  wire logic                   i_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    input  wire logic [TDATA_OUT_W-1:0] i_m_axis_tdata,   // similarity [15:0]
    input  wire logic                   i_m_axis_tuser,   // zero_norm
    output int                          o_error_count,
    output int                          o_pending
);

    localparam int ACC_W      = 40;
    localparam int MAX_REPORT = 10;

    typedef struct packed {
        logic signed [DATA_W-1:0] similarity;
        logic                     zero_norm;
    } t_cos_word;

    t_cos_word               expected_words[$];
    logic signed [ACC_W-1:0] dot_acc;
    logic [ACC_W-1:0]        sq_a_acc;
    logic [ACC_W-1:0]        sq_b_acc;
    logic [7:0]              pair_count;
    int                      error_count = 0;

    // largest q in 0..32768 with q^2 * |A|^2 * |B|^2 <= dot^2 * 2^30
    function automatic t_cos_word cosine_of(input logic signed [ACC_W-1:0] dot,
                                            input logic [ACC_W-1:0] sq_a,
                                            input logic [ACC_W-1:0] sq_b);
        t_cos_word    w;
        logic [127:0] dot_mag;
        logic [127:0] bound;
        logic [127:0] norm_prod;
        logic [127:0] trial;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        w.zero_norm  = 1'b0;
        w.similarity = '0;
        if (sq_a == 0 || sq_b == 0) begin
            w.zero_norm = 1'b1;
            return w;
        end
        dot_mag   = (dot < 0) ? 128'(-dot) : 128'(dot);
        bound     = (dot_mag * dot_mag) << FRAC_W;
        norm_prod = 128'(sq_a) * 128'(sq_b);
        lo = 0;
        hi = 32768;
        while (lo < hi) begin
            mid   = (lo + hi + 1) / 2;
            trial = norm_prod * 128'(mid * mid);
            if (trial <= bound) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        if (dot < 0) begin
            w.similarity = DATA_W'(0 - lo);
        end else begin
            w.similarity = (lo > SIM_MAX) ? SIM_MAX : DATA_W'(lo);
        end
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_cos_word                want;
        t_cos_word                got;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        if (!i_rst_n) begin
            dot_acc    = '0;
            sq_a_acc   = '0;
            sq_b_acc   = '0;
            pair_count = '0;
            expected_words.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.similarity = i_m_axis_tdata;
                got.zero_norm  = i_m_axis_tuser;
                if (expected_words.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORT)
                        $display("%0t: unexpected result word: similarity %0d zero_norm %0b",
                                 $realtime, got.similarity, got.zero_norm);
                end else begin
                    want = expected_words.pop_front();
                    if (got.similarity !== want.similarity || got.zero_norm !== want.zero_norm)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORT)
                            $display("%0t: mismatch: similarity exp %0d got %0d, %s%0b got %0b",
                                     $realtime, want.similarity, got.similarity,
                                     "zero_norm exp ", want.zero_norm, got.zero_norm);
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                a = i_s_axis_tdata[DATA_W-1:0];
                b = i_s_axis_tdata[2*DATA_W-1:DATA_W];
                // pairs past MAX_LEN are dropped, the marked one too
                if (pair_count < MAX_LEN) begin
                    dot_acc    = dot_acc + ACC_W'(a) * ACC_W'(b);
                    sq_a_acc   = sq_a_acc + ACC_W'(a) * ACC_W'(a);
                    sq_b_acc   = sq_b_acc + ACC_W'(b) * ACC_W'(b);
                    pair_count = pair_count + 1'b1;
                end
                if (i_s_axis_tlast) begin
                    expected_words.push_back(cosine_of(dot_acc, sq_a_acc, sq_b_acc));
                    dot_acc    = '0;
                    sq_a_acc   = '0;
                    sq_b_acc   = '0;
                    pair_count = '0;
                end
            end
        end
        o_error_count <= error_count;
        o_pending     <= expected_words.size();
    end

endmodule

// ===== test/cosine_similarity_unit_test.sv =====
// Testbench top for the cosine similarity unit: clock, reset, vector stimulus and verdict.
`timescale 1ns / 1ps

module cosine_similarity_unit_test;
    import csim_pkg::*;

    localparam int RANDOM_ITEMS = 1000;
    localparam int DRAIN_LIMIT  = 50000;
    localparam int SETTLE_TIME  = 300;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} t_rx_mode;
    typedef enum int {VEC_PLAIN, VEC_SAME, VEC_OPPOSITE, VEC_SCALED,
                      VEC_ZERO, VEC_EXTREME, VEC_SMALL} t_vec_kind;

    logic                   i_clk;
    logic                   i_rst_n         = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic [TDATA_IN_W-1:0]  i_s_axis_tdata  = '0;   // elem_a [15:0], elem_b [31:16]
    logic                   i_s_axis_tlast  = 1'b0; // last_elem
    logic                   i_m_axis_tready = 1'b0;
    wire logic              o_s_axis_tready;
    wire logic              o_m_axis_tvalid;
    wire logic [TDATA_OUT_W-1:0] o_m_axis_tdata;    // similarity [15:0]
    wire logic              o_m_axis_tuser;         // zero_norm

    int       error_count;
    int       pending;
    int       burst_left  = 0;
    int       random_sent = 0;
    bit       drain_ok    = 1'b1;
    bit       paused_mid  = 1'b0;
    t_rx_mode rx_mode     = RX_OPEN;
    int       rx_left     = 0;

    cosine_similarity_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    cosine_similarity_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .i_m_axis_tuser  (o_m_axis_tuser),
        .o_error_count   (error_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 300);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   i_m_axis_tready <= 1'b1;
            RX_COIN:   i_m_axis_tready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: i_m_axis_tready <= ($urandom_range(0, 7) == 0);
            default:   i_m_axis_tready <= rx_left[3];
        endcase
    end

    task automatic send_pair(input logic signed [DATA_W-1:0] a,
                             input logic signed [DATA_W-1:0] b,
                             input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 25) : $urandom_range(0, 3);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_axis_tdata  <= {b, a};
        i_s_axis_tlast  <= last;
        i_s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    // hold the sender off until every expected word is back
    task automatic wait_for_results(input int limit);
        int cycles;
        cycles = 0;
        i_s_axis_tvalid <= 1'b0;
        do begin
            @(posedge i_clk);
            cycles++;
        end while (pending != 0 && cycles < limit);
        if (pending != 0)
            drain_ok = 1'b0;
        burst_left = 0;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_extreme();
        case ($urandom_range(0, 4))
            0:       return 16'sh8000;
            1:       return -16'sd1;
            2:       return 16'sd0;
            3:       return 16'sd1;
            default: return 16'sh7FFF;
        endcase
    endfunction

    task automatic send_vector(input t_vec_kind kind, input int len);
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        int                       zero_side;
        zero_side = $urandom_range(0, 2);
        for (int i = 0; i < len; i++) begin
            a = DATA_W'($urandom);
            b = DATA_W'($urandom);
            case (kind)
                VEC_SAME:     b = a;
                VEC_OPPOSITE: b = -a;
                VEC_SCALED:   b = a >>> $urandom_range(0, 6);
                VEC_ZERO: begin
                    if (zero_side != 1) a = '0;
                    if (zero_side != 0) b = '0;
                end
                VEC_EXTREME: begin
                    a = pick_extreme();
                    b = pick_extreme();
                end
                VEC_SMALL: begin
                    a = DATA_W'(int'($urandom_range(0, 8)) - 4);
                    b = DATA_W'(int'($urandom_range(0, 8)) - 4);
                end
                default: ;
            endcase
            send_pair(a, b, i == len - 1);
            random_sent++;
        end
    endtask

    initial begin
        t_vec_kind kind;
        int        pick;
        int        len;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-pair vectors: saturation at +1, exact -1, zero norms
        send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
        send_pair(16'sh8000, 16'sh8000, 1'b1);
        send_pair(16'sh8000, 16'sh7FFF, 1'b1);
        send_pair(16'sd16384, -16'sd16384, 1'b1);
        send_pair(16'sd0, 16'sd1234, 1'b1);
        send_pair(-16'sd77, 16'sd0, 1'b1);
        send_pair(16'sd0, 16'sd0, 1'b1);
        send_pair(16'sd1, 16'sh7FFF, 1'b1);
        // short vectors
        send_pair(16'sh7FFF, 16'sh8000, 1'b0);
        send_pair(16'sh8000, 16'sh7FFF, 1'b1);
        send_pair(16'sd1, -16'sd1, 1'b0);
        send_pair(16'sd0, 16'sd0, 1'b0);
        send_pair(-16'sd1, 16'sd1, 1'b1);
        send_pair(16'sd12000, -16'sd3000, 1'b0);
        send_pair(-16'sd25000, 16'sd8000, 1'b0);
        send_pair(16'sd300, 16'sd30000, 1'b1);
        send_pair(16'sd1000, 16'sd0, 1'b0);
        send_pair(16'sd0, 16'sd1000, 1'b1);
        wait_for_results(DRAIN_LIMIT);

        // one vector past MAX_LEN first, then the random mix
        send_vector(VEC_PLAIN, MAX_LEN_DEF + 2);
        while (random_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 199);
            len  = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 8);
            if (pick < 2) begin
                kind = VEC_PLAIN;
                len  = $urandom_range(MAX_LEN_DEF - 3, MAX_LEN_DEF + 7);
            end else if (pick < 110) begin
                kind = VEC_PLAIN;
            end else if (pick < 130) begin
                kind = VEC_SAME;
            end else if (pick < 145) begin
                kind = VEC_OPPOSITE;
            end else if (pick < 160) begin
                kind = VEC_SCALED;
            end else if (pick < 175) begin
                kind = VEC_ZERO;
            end else if (pick < 190) begin
                kind = VEC_EXTREME;
            end else begin
                kind = VEC_SMALL;
            end
            send_vector(kind, len);
            if (!paused_mid && random_sent >= RANDOM_ITEMS / 2) begin
                paused_mid = 1'b1;
                wait_for_results(DRAIN_LIMIT);
            end
        end

        wait_for_results(DRAIN_LIMIT);
        if (!drain_ok) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            repeat (SETTLE_TIME) @(posedge i_clk);
            if (error_count == 0 && pending == 0) begin
                $display("Testbench completed without errors");
            end else begin
                $display("Testbench completed WITH ERRORS");
            end
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
design/csim_pkg.sv
design/cosine_similarity_unit.sv
design/csim_checker.sv
test/cosine_similarity_checker.sv
test/cosine_similarity_unit_test.sv
